// File: rtl/frx_pkg.sv
// Shared constants and types for the framed packet receiver.
// No dependencies; imported by the receiver and its checker.
package frx_pkg;

  localparam int PAYLOAD_DEPTH = 16;
  localparam int TYPE_SLOTS    = 8;

  localparam int LEN_W      = $clog2(PAYLOAD_DEPTH + 1);
  localparam int ADDR_W     = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int BYTE_IDX_W = 6;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] NACK_BYTE  = 8'h3F;

  localparam logic [7:0]  MAX_RETRIES_RST  = 8'd3;
  localparam logic [3:0]  TYPE_COUNT_RST   = 4'd8;
  localparam logic [63:0] LENGTH_TABLE_RST = 64'd0;

  // register indexes, decoded from paddr[4:3]
  localparam logic [1:0] REG_MAX_RETRIES  = 2'd0;
  localparam logic [1:0] REG_TYPE_COUNT   = 2'd1;
  localparam logic [1:0] REG_LENGTH_TABLE = 2'd2;

  typedef enum logic [2:0] {
    EV_RESEND = 3'd0,
    EV_FLUSH  = 3'd1,
    EV_ACK    = 3'd2,
    EV_ACCEPT = 3'd3,
    EV_REJECT = 3'd4
  } ev_t;

endpackage

// File: rtl/frx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.
module frx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/framed_packet_receiver.sv
// Framed packet receiver: takes one link byte per request and returns events.
// A frame is start byte 0x7E, type, payload (length from length_table, clamped to
// the buffer depth) and a checksum that must equal the 8-bit sum of type and payload.
// Idle '?' bytes give resend events, or a flush event once the retries are used up.
// A byte causing one result is taken while the previous result waits
// if out_ready drains it that cycle. A good frame with n payload bytes opens an
// accept run of n results read back from the payload RAM; each result is a RAM
// read, then a load into the output register, and in_ready stays low for the
// whole run. No clearing pass follows reset. Depends on frx_pkg and frx_ram.
module framed_packet_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_event_res,
  output logic [2:0]                        out_frame_type,
  output logic [7:0]                        out_payload_byte,
  output logic [frx_pkg::BYTE_IDX_W-1:0]    out_byte_index,
  output logic                              out_has_payload,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [frx_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [frx_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [frx_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import frx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TYPE  = 5'b00010,
    S_DATA  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  // configuration
  logic [7:0]  max_retries_r;
  logic [3:0]  type_count_r;
  logic [63:0] length_table_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MAX_RETRIES:  prdata = CFG_DATA_W'(max_retries_r);
      REG_TYPE_COUNT:   prdata = CFG_DATA_W'(type_count_r);
      REG_LENGTH_TABLE: prdata = length_table_r;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r  <= MAX_RETRIES_RST;
      type_count_r   <= TYPE_COUNT_RST;
      length_table_r <= LENGTH_TABLE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAX_RETRIES:  max_retries_r  <= pwdata[7:0];
        REG_TYPE_COUNT:   type_count_r   <= pwdata[3:0];
        REG_LENGTH_TABLE: length_table_r <= pwdata;
        default: ;
      endcase
    end
  end

  // frame state
  state_t            state_r, state_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [2:0]        type_r, type_nxt;
  logic [LEN_W-1:0]  frame_len_r, frame_len_nxt;
  logic [LEN_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [7:0]        retries_r, retries_nxt;
  logic [LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [ADDR_W-1:0] rd_pend_idx_r, rd_pend_idx_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_ld;
  logic [2:0]        ev_r, ev_nxt;
  logic [2:0]        ftype_r, ftype_nxt;
  logic [7:0]        pbyte_r, pbyte_nxt;
  logic [BYTE_IDX_W-1:0] bidx_r, bidx_nxt;
  logic              has_r, has_nxt;
  logic              last_r, last_nxt;

  logic              in_fire;
  logic              out_free;
  logic              rd_issue;
  logic [3:0]        type_limit;
  logic [7:0]        len_raw;
  logic [LEN_W-1:0]  len_clamped;
  logic [7:0]        ram_rdata;
  logic              ram_we;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r != S_DRAIN) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign type_limit = (type_count_r > 4'(TYPE_SLOTS)) ? 4'(TYPE_SLOTS) : type_count_r;
  assign len_raw    = length_table_r[8*in_rx_byte[2:0] +: 8];
  assign len_clamped = (len_raw > 8'(PAYLOAD_DEPTH)) ? LEN_W'(PAYLOAD_DEPTH)
                                                     : LEN_W'(len_raw);

  // one read in flight at a time, issued only when the output slot will be empty
  assign rd_issue = (state_r == S_DRAIN) && !rd_pend_r && (rd_idx_r != frame_len_r)
                    && out_free;
  assign ram_we   = in_fire && (state_r == S_DATA);

  frx_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r[ADDR_W-1:0]),
    .wdata (in_rx_byte),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    sum_nxt         = sum_r;
    type_nxt        = type_r;
    frame_len_nxt   = frame_len_r;
    wr_idx_nxt      = wr_idx_r;
    retries_nxt     = retries_r;
    rd_idx_nxt      = rd_idx_r;
    rd_pend_nxt     = rd_issue;
    rd_pend_idx_nxt = rd_issue ? rd_idx_r[ADDR_W-1:0] : rd_pend_idx_r;
    out_ld          = 1'b0;
    ev_nxt          = ev_r;
    ftype_nxt       = 3'd0;
    pbyte_nxt       = 8'd0;
    bidx_nxt        = '0;
    has_nxt         = 1'b0;
    last_nxt        = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_rx_byte == START_BYTE) begin
            state_nxt = S_TYPE;
            sum_nxt   = 8'd0;
          end else if (in_rx_byte == NACK_BYTE) begin
            out_ld = 1'b1;
            if (retries_r != 8'd0) begin
              retries_nxt = retries_r - 8'd1;
              ev_nxt      = EV_RESEND;
            end else begin
              retries_nxt = max_retries_r;
              ev_nxt      = EV_FLUSH;
            end
          end
        end
      end
      S_TYPE: begin
        if (in_fire) begin
          if (in_rx_byte >= {4'd0, type_limit}) begin
            state_nxt = S_IDLE;
            out_ld    = 1'b1;
            ev_nxt    = EV_ACK;
          end else begin
            sum_nxt       = sum_r + in_rx_byte;
            type_nxt      = in_rx_byte[2:0];
            frame_len_nxt = len_clamped;
            wr_idx_nxt    = '0;
            state_nxt     = (len_clamped != '0) ? S_DATA : S_CHECK;
          end
        end
      end
      S_DATA: begin
        if (in_fire) begin
          sum_nxt    = sum_r + in_rx_byte;
          wr_idx_nxt = wr_idx_r + LEN_W'(1);
          if (wr_idx_r + LEN_W'(1) == frame_len_r) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (in_fire) begin
          state_nxt = S_IDLE;
          ftype_nxt = type_r;
          if (sum_r != in_rx_byte) begin
            out_ld = 1'b1;
            ev_nxt = EV_REJECT;
          end else if (frame_len_r == '0) begin
            out_ld = 1'b1;
            ev_nxt = EV_ACCEPT;
          end else begin
            state_nxt  = S_DRAIN;
            rd_idx_nxt = '0;
          end
        end
      end
      S_DRAIN: begin
        if (rd_issue) begin
          rd_idx_nxt = rd_idx_r + LEN_W'(1);
        end
        // read data lands in an output slot that is known to be empty
        if (rd_pend_r) begin
          out_ld    = 1'b1;
          ev_nxt    = EV_ACCEPT;
          ftype_nxt = type_r;
          pbyte_nxt = ram_rdata;
          bidx_nxt  = BYTE_IDX_W'(rd_pend_idx_r);
          has_nxt   = 1'b1;
          last_nxt  = (LEN_W'(rd_pend_idx_r) + LEN_W'(1)) == frame_len_r;
          if (last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= 8'd0;
      type_r      <= 3'd0;
      frame_len_r <= '0;
      wr_idx_r    <= '0;
      retries_r   <= MAX_RETRIES_RST;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      type_r      <= type_nxt;
      frame_len_r <= frame_len_nxt;
      wr_idx_r    <= wr_idx_nxt;
      retries_r   <= retries_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pend_idx_r <= rd_pend_idx_nxt;
    if (out_ld) begin
      ev_r    <= ev_nxt;
      ftype_r <= ftype_nxt;
      pbyte_r <= pbyte_nxt;
      bidx_r  <= bidx_nxt;
      has_r   <= has_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_frame_type   = ftype_r;
  assign out_payload_byte = pbyte_r;
  assign out_byte_index   = bidx_r;
  assign out_has_payload  = has_r;
  assign out_last         = last_r;

endmodule

// File: rtl/frx_check.sv
// Port-level assertions for the framed packet receiver, bound to the top level.
// Depends on frx_pkg for event codes.
module frx_check (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [2:0]                     out_event_res,
  input logic [2:0]                     out_frame_type,
  input logic [7:0]                     out_payload_byte,
  input logic [frx_pkg::BYTE_IDX_W-1:0] out_byte_index,
  input logic                           out_has_payload,
  input logic                           out_last
);
  import frx_pkg::*;

  // only accept runs carry payload
  a_payload_is_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_payload |-> out_event_res == EV_ACCEPT)
    else $error("payload on a non-accept result");

  a_no_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_payload |->
      out_payload_byte == 8'd0 && out_byte_index == '0 && out_last)
    else $error("empty result with stray payload fields");

  // no new byte is taken until an accept run has been fully delivered
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_payload && !out_last |-> !in_ready)
    else $error("input taken during an accept run");

  a_link_events_untyped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_RESEND || out_event_res == EV_FLUSH ||
                  out_event_res == EV_ACK) |-> out_frame_type == 3'd0)
    else $error("link event with a frame type");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
                                && $stable(out_event_res))
    else $error("stalled result changed");

endmodule

bind framed_packet_receiver frx_check u_frx_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_res    (out_event_res),
  .out_frame_type   (out_frame_type),
  .out_payload_byte (out_payload_byte),
  .out_byte_index   (out_byte_index),
  .out_has_payload  (out_has_payload),
  .out_last         (out_last)
);
